// ===== rtl/software_timer_bank_defines.svh =====
// Assertion macros for the software timer bank.
`ifndef SOFTWARE_TIMER_BANK_DEFINES_SVH
`define SOFTWARE_TIMER_BANK_DEFINES_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define STB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Check that cons holds in the cycle after ante.
`define STB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define STB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define STB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/stb_pkg.sv =====
package stb_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int TIME_WIDTH_DEF = 48;

  // Request codes
  localparam logic [2:0] REQ_CREATE   = 3'd0;
  localparam logic [2:0] REQ_DROP     = 3'd1;
  localparam logic [2:0] REQ_DROP_ALL = 3'd2;
  localparam logic [2:0] REQ_PAUSE    = 3'd3;
  localparam logic [2:0] REQ_RESUME   = 3'd4;
  localparam logic [2:0] REQ_RESTART  = 3'd5;
  localparam logic [2:0] REQ_TICK     = 3'd6;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_FIND_STEP,
    OP_CREATE,
    OP_CREATE_FULL,
    OP_DROP,
    OP_DROP_ALL,
    OP_READ_SLOT,
    OP_PAUSE,
    OP_RESUME,
    OP_RESTART,
    OP_ACK,
    OP_NOW_ADV,
    OP_SCAN_RD,
    OP_SCAN_EV,
    OP_TICK_END
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIND,
    S_FINISH,
    S_SCAN_RD,
    S_SCAN_EV,
    S_TICK_END
  } ctrl_state_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       free_hit;
    logic       fire;
    logic       idx_last;
    logic       out_free;
  } sts_t;

endpackage

// ===== rtl/stb_ifs.sv =====
interface stb_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [4:0]  timer_id;
  logic [31:0] period;
  logic        repeat_flag;
  logic [31:0] elapsed;
  modport source(output valid, req_type, timer_id, period, repeat_flag, elapsed,
                 input ready);
  modport sink(input valid, req_type, timer_id, period, repeat_flag, elapsed,
               output ready);
endinterface

interface stb_evt_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic [4:0] slot_id;
  logic       status;
  logic       last;
  modport source(output valid, event_kind, slot_id, status, last, input ready);
  modport sink(input valid, event_kind, slot_id, status, last, output ready);
endinterface

// ===== rtl/stb_ctrl.sv =====
module stb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  stb_pkg::sts_t sts_i,
  output stb_pkg::cmd_t cmd_o
);

  stb_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stb_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = stb_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      stb_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = stb_pkg::OP_LATCH;
          state_d  = stb_pkg::S_DISPATCH;
        end
      end
      stb_pkg::S_DISPATCH: begin
        unique case (sts_i.req)
          stb_pkg::REQ_CREATE: state_d = stb_pkg::S_FIND;
          stb_pkg::REQ_PAUSE, stb_pkg::REQ_RESUME, stb_pkg::REQ_RESTART: begin
            cmd_o.op = stb_pkg::OP_READ_SLOT;
            state_d  = stb_pkg::S_FINISH;
          end
          stb_pkg::REQ_TICK: begin
            cmd_o.op = stb_pkg::OP_NOW_ADV;
            state_d  = stb_pkg::S_SCAN_RD;
          end
          default: state_d = stb_pkg::S_FINISH;
        endcase
      end
      stb_pkg::S_FIND: begin
        if (sts_i.free_hit) begin
          if (sts_i.out_free) begin
            cmd_o.op = stb_pkg::OP_CREATE;
            state_d  = stb_pkg::S_IDLE;
          end
        end else if (sts_i.idx_last) begin
          if (sts_i.out_free) begin
            cmd_o.op = stb_pkg::OP_CREATE_FULL;
            state_d  = stb_pkg::S_IDLE;
          end
        end else begin
          cmd_o.op = stb_pkg::OP_FIND_STEP;
        end
      end
      stb_pkg::S_FINISH: begin
        if (sts_i.out_free) begin
          state_d = stb_pkg::S_IDLE;
          unique case (sts_i.req)
            stb_pkg::REQ_DROP:     cmd_o.op = stb_pkg::OP_DROP;
            stb_pkg::REQ_DROP_ALL: cmd_o.op = stb_pkg::OP_DROP_ALL;
            stb_pkg::REQ_PAUSE:    cmd_o.op = stb_pkg::OP_PAUSE;
            stb_pkg::REQ_RESUME:   cmd_o.op = stb_pkg::OP_RESUME;
            stb_pkg::REQ_RESTART:  cmd_o.op = stb_pkg::OP_RESTART;
            default:               cmd_o.op = stb_pkg::OP_ACK;
          endcase
        end
      end
      stb_pkg::S_SCAN_RD: begin
        cmd_o.op = stb_pkg::OP_SCAN_RD;
        state_d  = stb_pkg::S_SCAN_EV;
      end
      stb_pkg::S_SCAN_EV: begin
        // hold while an expiry beat has nowhere to go
        if (!sts_i.fire || sts_i.out_free) begin
          cmd_o.op = stb_pkg::OP_SCAN_EV;
          state_d  = sts_i.idx_last ? stb_pkg::S_TICK_END : stb_pkg::S_SCAN_RD;
        end
      end
      stb_pkg::S_TICK_END: begin
        if (sts_i.out_free) begin
          cmd_o.op = stb_pkg::OP_TICK_END;
          state_d  = stb_pkg::S_IDLE;
        end
      end
      default: state_d = stb_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/stb_datapath.sv =====
module stb_datapath #(
  parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF,
  parameter int TIME_WIDTH = stb_pkg::TIME_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  stb_pkg::cmd_t cmd_i,
  output stb_pkg::sts_t sts_o,
  input  logic [2:0]    req_type_i,
  input  logic [4:0]    timer_id_i,
  input  logic [31:0]   period_i,
  input  logic          repeat_flag_i,
  input  logic [31:0]   elapsed_i,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic          event_kind_o,
  output logic [4:0]    slot_id_o,
  output logic          status_o,
  output logic          last_o
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  function automatic logic [TIME_WIDTH-1:0] sat_add(logic [TIME_WIDTH-1:0] a,
                                                    logic [31:0] b);
    logic [TIME_WIDTH:0] s;
    s = {1'b0, a} + (TIME_WIDTH+1)'(b);
    return s[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : s[TIME_WIDTH-1:0];
  endfunction

  // latched request
  logic [2:0]  req_type_q;
  logic [4:0]  tid_q;
  logic [31:0] per_q;
  logic        rep_q;
  logic [31:0] el_q;

  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [TIME_WIDTH-1:0] now_q, now_d;

  logic [NUM_TIMERS-1:0] active_q, active_d;
  logic [NUM_TIMERS-1:0] padd_q, padd_d;
  logic [NUM_TIMERS-1:0] pdrop_q, pdrop_d;
  logic [NUM_TIMERS-1:0] paused_q, paused_d;
  logic [NUM_TIMERS-1:0] repeats_q, repeats_d;

  logic [TIME_WIDTH-1:0] tgt_mem [NUM_TIMERS];
  logic [31:0]           per_mem [NUM_TIMERS];
  logic [31:0]           rem_mem [NUM_TIMERS];
  logic [TIME_WIDTH-1:0] tgt_rd_q;
  logic [31:0]           per_rd_q;
  logic [31:0]           rem_rd_q;

  logic                  out_valid_q, out_valid_d;
  logic                  kind_q, kind_d;
  logic [4:0]            sid_out_q, sid_out_d;
  logic                  st_q, st_d;
  logic                  last_q, last_d;

  logic                  id_ok;
  logic [IDX_W-1:0]      sid;
  logic                  idx_last;
  logic                  fire;
  logic                  out_free;
  logic [31:0]           add_b;
  logic [TIME_WIDTH-1:0] add_sum;
  logic [TIME_WIDTH-1:0] diff;
  logic [63:0]           diff_ext;
  logic [31:0]           rem_new;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  tgt_we, per_we, rem_we;
  logic [IDX_W-1:0]      wr_addr;
  logic                  cond_pause, cond_resume, cond_restart;
  logic                  emit;

  assign id_ok    = (tid_q != 5'd0) && (32'(tid_q) <= 32'(NUM_TIMERS));
  assign sid      = id_ok ? IDX_W'(32'(tid_q) - 32'd1) : '0;
  assign idx_last = (idx_q == IDX_W'(NUM_TIMERS - 1));
  assign fire     = active_q[idx_q] && !paused_q[idx_q] && (tgt_rd_q < now_q);
  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.req      = req_type_q;
  assign sts_o.free_hit = !active_q[idx_q] && !padd_q[idx_q];
  assign sts_o.fire     = fire;
  assign sts_o.idx_last = idx_last;
  assign sts_o.out_free = out_free;

  assign cond_pause   = id_ok && active_q[sid] && !paused_q[sid];
  assign cond_resume  = id_ok && active_q[sid] && paused_q[sid];
  assign cond_restart = id_ok && active_q[sid];

  // shared saturating adder
  always_comb begin
    unique case (cmd_i.op)
      stb_pkg::OP_CREATE:  add_b = per_q;
      stb_pkg::OP_RESUME:  add_b = rem_rd_q;
      stb_pkg::OP_NOW_ADV: add_b = el_q;
      default:             add_b = per_rd_q;
    endcase
  end
  assign add_sum = sat_add(now_q, add_b);

  // remaining time, clamped to zero and to 32 bits
  assign diff     = tgt_rd_q - now_q;
  assign diff_ext = 64'(diff);
  assign rem_new  = !(tgt_rd_q > now_q) ? 32'd0 :
                    (diff_ext[63:32] != 32'd0) ? 32'hFFFF_FFFF : diff_ext[31:0];

  assign rd_en   = (cmd_i.op == stb_pkg::OP_READ_SLOT) || (cmd_i.op == stb_pkg::OP_SCAN_RD);
  assign rd_addr = (cmd_i.op == stb_pkg::OP_READ_SLOT) ? sid : idx_q;

  assign tgt_we = (cmd_i.op == stb_pkg::OP_CREATE) ||
                  ((cmd_i.op == stb_pkg::OP_RESUME) && cond_resume) ||
                  ((cmd_i.op == stb_pkg::OP_RESTART) && cond_restart) ||
                  ((cmd_i.op == stb_pkg::OP_SCAN_EV) && fire && repeats_q[idx_q]);
  assign per_we = (cmd_i.op == stb_pkg::OP_CREATE);
  assign rem_we = (cmd_i.op == stb_pkg::OP_PAUSE) && cond_pause;
  assign wr_addr = ((cmd_i.op == stb_pkg::OP_CREATE) || (cmd_i.op == stb_pkg::OP_SCAN_EV)) ?
                   idx_q : sid;

  always_ff @(posedge clk_i) begin
    if (tgt_we) tgt_mem[wr_addr] <= add_sum;
    if (per_we) per_mem[wr_addr] <= per_q;
    if (rem_we) rem_mem[wr_addr] <= rem_new;
    if (rd_en) begin
      tgt_rd_q <= tgt_mem[rd_addr];
      per_rd_q <= per_mem[rd_addr];
      rem_rd_q <= rem_mem[rd_addr];
    end
  end

  always_comb begin
    idx_d     = idx_q;
    now_d     = now_q;
    active_d  = active_q;
    padd_d    = padd_q;
    pdrop_d   = pdrop_q;
    paused_d  = paused_q;
    repeats_d = repeats_q;
    emit      = 1'b0;
    kind_d    = 1'b0;
    sid_out_d = 5'd0;
    st_d      = 1'b0;
    last_d    = 1'b1;
    unique case (cmd_i.op)
      stb_pkg::OP_LATCH: idx_d = '0;
      stb_pkg::OP_FIND_STEP: idx_d = idx_last ? '0 : idx_q + 1'b1;
      stb_pkg::OP_CREATE: begin
        repeats_d[idx_q] = rep_q;
        paused_d[idx_q]  = 1'b0;
        pdrop_d[idx_q]   = 1'b0;
        padd_d[idx_q]    = 1'b1;
        emit             = 1'b1;
        sid_out_d        = 5'(32'(idx_q) + 32'd1);
      end
      stb_pkg::OP_CREATE_FULL: begin
        emit = 1'b1;
        st_d = 1'b1;
      end
      stb_pkg::OP_DROP: begin
        if (id_ok && active_q[sid]) pdrop_d[sid] = 1'b1;
        emit = 1'b1;
      end
      stb_pkg::OP_DROP_ALL: begin
        active_d = '0;
        padd_d   = '0;
        pdrop_d  = '0;
        paused_d = '0;
        emit     = 1'b1;
      end
      stb_pkg::OP_PAUSE: begin
        if (cond_pause) paused_d[sid] = 1'b1;
        emit = 1'b1;
      end
      stb_pkg::OP_RESUME: begin
        if (cond_resume) paused_d[sid] = 1'b0;
        emit = 1'b1;
      end
      stb_pkg::OP_RESTART: begin
        if (cond_restart) paused_d[sid] = 1'b0;
        emit = 1'b1;
      end
      stb_pkg::OP_ACK: emit = 1'b1;
      stb_pkg::OP_NOW_ADV: now_d = add_sum;
      stb_pkg::OP_SCAN_EV: begin
        if (fire) begin
          if (!repeats_q[idx_q]) pdrop_d[idx_q] = 1'b1;
          emit      = 1'b1;
          kind_d    = 1'b1;
          sid_out_d = 5'(32'(idx_q) + 32'd1);
          last_d    = 1'b0;
        end
        idx_d = idx_last ? '0 : idx_q + 1'b1;
      end
      stb_pkg::OP_TICK_END: begin
        // free dropped slots, then promote pending ones
        active_d = (active_q & ~pdrop_q) | padd_q;
        paused_d = paused_q & ~pdrop_q;
        pdrop_d  = '0;
        padd_d   = '0;
        emit     = 1'b1;
      end
      default: ;
    endcase
    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      now_q       <= '0;
      active_q    <= '0;
      padd_q      <= '0;
      pdrop_q     <= '0;
      paused_q    <= '0;
      repeats_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      now_q       <= now_d;
      active_q    <= active_d;
      padd_q      <= padd_d;
      pdrop_q     <= pdrop_d;
      paused_q    <= paused_d;
      repeats_q   <= repeats_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == stb_pkg::OP_LATCH) begin
      req_type_q <= req_type_i;
      tid_q      <= timer_id_i;
      per_q      <= period_i;
      rep_q      <= repeat_flag_i;
      el_q       <= elapsed_i;
    end
    if (emit) begin
      kind_q    <= kind_d;
      sid_out_q <= sid_out_d;
      st_q      <= st_d;
      last_q    <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = kind_q;
  assign slot_id_o    = sid_out_q;
  assign status_o     = st_q;
  assign last_o       = last_q;

endmodule

// ===== rtl/software_timer_bank.sv =====
// Bank of NUM_TIMERS one-shot or repeating timers sharing one saturating
// time counter. One request is handled at a time; every request ends with
// exactly one acknowledge beat (last = 1), and a tick puts its expiry beats
// (last = 0, ascending slot id) before that. Per request, after the accept:
// drop, drop all and unknown codes go through dispatch and finish; pause,
// resume and restart add one registered read of the slot stores; create
// walks the flags in a free-slot search, one slot per cycle; and a tick
// scans the slots in turn, for each one reading the target and period
// store, then comparing and re-arming. A stalled result side holds the
// block in place. A new timer becomes active at the end of the next tick;
// a drop takes effect at the end of the next tick, so the timer may fire
// once more. The stores need no clearing after reset.
`include "software_timer_bank_defines.svh"

module software_timer_bank #(
  parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF,
  parameter int TIME_WIDTH = stb_pkg::TIME_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  stb_req_if.sink    req_i,
  stb_evt_if.source  evt_o
);

  stb_pkg::cmd_t cmd;
  stb_pkg::sts_t sts;

  // sequencer: decodes the request and steps through the slots
  stb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // slot flags, time counter, slot stores and the result register
  stb_datapath #(
    .NUM_TIMERS (NUM_TIMERS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (req_i.req_type),
    .timer_id_i    (req_i.timer_id),
    .period_i      (req_i.period),
    .repeat_flag_i (req_i.repeat_flag),
    .elapsed_i     (req_i.elapsed),
    .out_ready_i   (evt_o.ready),
    .out_valid_o   (evt_o.valid),
    .event_kind_o  (evt_o.event_kind),
    .slot_id_o     (evt_o.slot_id),
    .status_o      (evt_o.status),
    .last_o        (evt_o.last)
  );

  // one request at a time: no accept right after an accept
  `STB_ASSERT_NEXT(a_one_req, clk_i, rst_ni, req_i.valid && req_i.ready, !req_i.ready)
  // an expiry beat never closes a request
  `STB_ASSERT_IMPL(a_evt_not_last, clk_i, rst_ni, evt_o.valid && evt_o.event_kind, !evt_o.last)
  // a failed create carries no slot id
  `STB_ASSERT_IMPL(a_full_no_id, clk_i, rst_ni, evt_o.valid && evt_o.status,
                   evt_o.slot_id == 5'd0 && !evt_o.event_kind)

endmodule
